// ===== hdl/pss_pkg.sv =====
// pss_pkg: shared constants for the playlist shuffle sequencer.
// Mode codes, config register address, LCG constants, post-rebuild codes and fixed field widths. No dependencies.
package pss_pkg;

    localparam int SONG_W = 10;
    localparam int LEN_W  = 11;
    localparam int SEED_W = 31;

    localparam logic [2:0] MODE_LOAD    = 3'd0;
    localparam logic [2:0] MODE_NEXT    = 3'd1;
    localparam logic [2:0] MODE_PREV    = 3'd2;
    localparam logic [2:0] MODE_SELECT  = 3'd3;
    localparam logic [2:0] MODE_SHUFFLE = 3'd4;

    // config register byte address
    localparam logic [2:0] REG_LIST_LENGTH = 3'd0;

    localparam logic [SEED_W-1:0] LCG_MUL = 31'd1103515245;
    localparam logic [SEED_W-1:0] LCG_INC = 31'd12345;

    // what follows a rebuild of the order
    localparam logic [1:0] POST_NONE = 2'd0;
    localparam logic [1:0] POST_SWAP = 2'd1;
    localparam logic [1:0] POST_CUR  = 2'd2;

endpackage

// ===== hdl/pss_divmod.sv =====
// pss_divmod: iterative restoring remainder unit, one quotient bit per cycle.
// Depends on pss_pkg for the seed width.
module pss_divmod #(
    parameter int DW = 11,
    parameter int RW = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pss_pkg::SEED_W-1:0] dividend,
    input  logic [DW-1:0]             divisor,
    output logic                      done,
    output logic [RW-1:0]             remainder
);
    import pss_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [SEED_W-1:0]   dvd_reg, dvd_next;
    logic [DW-1:0]       div_reg, div_next;
    logic [DW-1:0]       rem_reg, rem_next;
    logic [DW:0]         shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        shifted   = {rem_reg, dvd_reg[SEED_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'(SEED_W);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, div_reg})
                rem_next = DW'(shifted - {1'b0, div_reg});
            else
                rem_next = DW'(shifted);
            dvd_next = {dvd_reg[SEED_W-2:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = RW'(rem_reg);

endmodule

// ===== hdl/pss_order_ram.sv =====
// pss_order_ram: play-order memory, one write and one registered read port.
// No package dependencies.
module pss_order_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [AW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [AW-1:0] rdata
);
    logic [AW-1:0] mem [DEPTH];
    logic [AW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/playlist_shuffle_sequencer_unit.sv =====
// playlist_shuffle_sequencer_unit: top level, sequencer, config port and outputs.
// Depends on pss_pkg, pss_divmod and pss_order_ram.
//
//  channel   | handshake               | word
//  ----------+-------------------------+----------------------------------------------
//  command   | start, busy             | mode, song_index, shuffle_request, entropy
//  result    | done (one-cycle strobe) | current_song, current_position, list_empty,
//            |                         | shuffle_active
//  config    | psel/penable/pwrite     | paddr, pwdata, prdata (list_length at 0x0)
//
// Steps: next/previous update the position and read out its song, and a next past the end
// rebuilds the order; select searches the order linearly; a rebuild writes the identity
// pass, then per entry of the shuffle pass an LCG multiply and add, the remainder unit and
// four memory accesses on the single read/write port pair; set-shuffle first reads the
// current song, and when turning shuffle on, a search for it and a swap to the front.
// Reset clears the position, the loaded flag and the length and sets shuffle on;
// the order memory is not cleared, every entry is written by a load before use.
// busy is high from the accepting edge until the done cycle; done is not held off.
module playlist_shuffle_sequencer_unit #(
    parameter int MAX_SONGS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // command
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  mode,
    input  logic [pss_pkg::SONG_W-1:0]  song_index,
    input  logic                        shuffle_request,
    input  logic [31:0]                 entropy,
    // result
    output logic                        done,
    output logic [pss_pkg::SONG_W-1:0]  current_song,
    output logic [pss_pkg::SONG_W-1:0]  current_position,
    output logic                        list_empty,
    output logic                        shuffle_active,
    // config
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pss_pkg::*;

    localparam int AW = $clog2(MAX_SONGS);
    localparam int LW = AW + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BUILD = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_ADD   = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_RDA   = 4'd5;
    localparam logic [3:0] S_RDB   = 4'd6;
    localparam logic [3:0] S_WRA   = 4'd7;
    localparam logic [3:0] S_WRB   = 4'd8;
    localparam logic [3:0] S_FRD   = 4'd9;
    localparam logic [3:0] S_FCMP  = 4'd10;
    localparam logic [3:0] S_RDCUR = 4'd11;
    localparam logic [3:0] S_CUR   = 4'd12;
    localparam logic [3:0] S_POST  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;
    localparam logic [3:0] S_OUT2  = 4'd15;

    // control state
    logic [3:0]        state_reg, state_next;
    logic              loaded_reg, loaded_next;
    logic              shuffle_on_reg, shuffle_on_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [LW-1:0]     held_len_reg, held_len_next;
    logic [LEN_W-1:0]  list_length_reg;

    // working registers
    logic [SEED_W-1:0] seed_reg, seed_next;
    logic [SEED_W-1:0] prod_reg, prod_next;
    logic [LW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     fy_i_reg, fy_i_next;
    logic [AW-1:0]     sw_a_reg, sw_a_next;
    logic [AW-1:0]     sw_b_reg, sw_b_next;
    logic [AW-1:0]     tmp_reg, tmp_next;
    logic [AW-1:0]     cur_reg, cur_next;
    logic [AW-1:0]     target_reg, target_next;
    logic [1:0]        post_reg, post_next;
    logic              in_fy_reg, in_fy_next;

    // memory and divider hookup
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_wdata, mem_raddr, mem_rdata;
    logic              div_start, div_done;
    logic [AW-1:0]     div_rem;

    logic              empty;
    logic [LW-1:0]     len_sat;
    logic              cfg_wr;

    assign empty   = !loaded_reg || (held_len_reg == '0);
    assign len_sat = (32'(list_length_reg) > 32'(MAX_SONGS)) ? LW'(MAX_SONGS)
                                                             : LW'(list_length_reg);

    pss_order_ram #(.DEPTH(MAX_SONGS), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pss_divmod #(.DW(LW), .RW(AW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (prod_reg + LCG_INC),
        .divisor   (LW'(fy_i_reg) + LW'(1)),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next      = state_reg;
        loaded_next     = loaded_reg;
        shuffle_on_next = shuffle_on_reg;
        pos_next        = pos_reg;
        held_len_next   = held_len_reg;
        seed_next       = seed_reg;
        prod_next       = prod_reg;
        cnt_next        = cnt_reg;
        fy_i_next       = fy_i_reg;
        sw_a_next       = sw_a_reg;
        sw_b_next       = sw_b_reg;
        tmp_next        = tmp_reg;
        cur_next        = cur_reg;
        target_next     = target_reg;
        post_next       = post_reg;
        in_fy_next      = in_fy_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        div_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    seed_next  = entropy[SEED_W-1:0];
                    post_next  = POST_NONE;
                    cnt_next   = '0;
                    state_next = S_OUT;
                    case (mode)
                        MODE_LOAD:
                        begin
                            held_len_next = len_sat;
                            loaded_next   = 1'b1;
                            state_next    = S_BUILD;
                        end
                        MODE_NEXT:
                        begin
                            if (!empty)
                            begin
                                if (LW'(pos_reg) + LW'(1) >= held_len_reg)
                                    state_next = S_BUILD;
                                else
                                    pos_next = pos_reg + AW'(1);
                            end
                        end
                        MODE_PREV:
                        begin
                            if (!empty && pos_reg != '0)
                                pos_next = pos_reg - AW'(1);
                        end
                        MODE_SELECT:
                        begin
                            if (!empty && 32'(song_index) < 32'(held_len_reg))
                            begin
                                target_next = AW'(song_index);
                                state_next  = S_FRD;
                            end
                        end
                        MODE_SHUFFLE:
                        begin
                            if (shuffle_request != shuffle_on_reg)
                            begin
                                shuffle_on_next = shuffle_request;
                                if (!empty)
                                begin
                                    post_next  = shuffle_request ? POST_SWAP : POST_CUR;
                                    state_next = S_RDCUR;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            // identity pass, then Fisher-Yates from the top when shuffling
            S_BUILD:
            begin
                if (cnt_reg == held_len_reg)
                begin
                    pos_next = '0;
                    if (shuffle_on_reg && held_len_reg > LW'(1))
                    begin
                        fy_i_next  = AW'(held_len_reg - LW'(1));
                        state_next = S_MUL;
                    end
                    else
                        state_next = S_POST;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg[AW-1:0];
                    mem_wdata = cnt_reg[AW-1:0];
                    cnt_next  = cnt_reg + LW'(1);
                end
            end
            S_MUL:
            begin
                prod_next  = SEED_W'(seed_reg * LCG_MUL);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                seed_next  = prod_reg + LCG_INC;
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    sw_a_next  = fy_i_reg;
                    sw_b_next  = div_rem;
                    in_fy_next = 1'b1;
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                mem_re     = 1'b1;
                mem_raddr  = sw_a_reg;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                mem_re     = 1'b1;
                mem_raddr  = sw_b_reg;
                tmp_next   = mem_rdata;
                state_next = S_WRA;
            end
            S_WRA:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sw_a_reg;
                mem_wdata  = mem_rdata;
                state_next = S_WRB;
            end
            S_WRB:
            begin
                mem_we    = 1'b1;
                mem_waddr = sw_b_reg;
                mem_wdata = tmp_reg;
                if (in_fy_reg)
                begin
                    if (fy_i_reg == AW'(1))
                        state_next = S_POST;
                    else
                    begin
                        fy_i_next  = fy_i_reg - AW'(1);
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    pos_next   = '0;
                    state_next = S_OUT;
                end
            end
            // linear search for target, a read and a compare per entry
            S_FRD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = cnt_reg[AW-1:0];
                state_next = S_FCMP;
            end
            S_FCMP:
            begin
                if (mem_rdata == target_reg || cnt_reg + LW'(1) == held_len_reg)
                begin
                    if (mem_rdata == target_reg)
                        sw_b_next = cnt_reg[AW-1:0];
                    else
                        sw_b_next = '0;
                    if (post_reg == POST_SWAP)
                    begin
                        sw_a_next  = '0;
                        in_fy_next = 1'b0;
                        state_next = S_RDA;
                    end
                    else
                    begin
                        pos_next   = (mem_rdata == target_reg) ? cnt_reg[AW-1:0] : '0;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + LW'(1);
                    state_next = S_FRD;
                end
            end
            S_RDCUR:
            begin
                mem_re     = 1'b1;
                mem_raddr  = pos_reg;
                state_next = S_CUR;
            end
            S_CUR:
            begin
                cur_next   = mem_rdata;
                state_next = S_BUILD;
            end
            S_POST:
            begin
                case (post_reg)
                    POST_SWAP:
                    begin
                        target_next = cur_reg;
                        cnt_next    = '0;
                        state_next  = S_FRD;
                    end
                    POST_CUR:
                    begin
                        pos_next   = cur_reg;
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_OUT:
            begin
                mem_re     = 1'b1;
                mem_raddr  = pos_reg;
                state_next = S_OUT2;
            end
            S_OUT2:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_LIST_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            loaded_reg      <= 1'b0;
            shuffle_on_reg  <= 1'b1;
            pos_reg         <= '0;
            held_len_reg    <= '0;
            list_length_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            loaded_reg     <= loaded_next;
            shuffle_on_reg <= shuffle_on_next;
            pos_reg        <= pos_next;
            held_len_reg   <= held_len_next;
            if (cfg_wr)
                list_length_reg <= pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg   <= seed_next;
        prod_reg   <= prod_next;
        cnt_reg    <= cnt_next;
        fy_i_reg   <= fy_i_next;
        sw_a_reg   <= sw_a_next;
        sw_b_reg   <= sw_b_next;
        tmp_reg    <= tmp_next;
        cur_reg    <= cur_next;
        target_reg <= target_next;
        post_reg   <= post_next;
        in_fy_reg  <= in_fy_next;
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = (state_reg == S_OUT2);
    assign current_song     = empty ? '0 : SONG_W'(mem_rdata);
    assign current_position = empty ? '0 : SONG_W'(pos_reg);
    assign list_empty       = empty;
    assign shuffle_active   = shuffle_on_reg;
    assign prdata           = (paddr == REG_LIST_LENGTH) ? 32'(list_length_reg) : 32'd0;
    assign pready           = 1'b1;

endmodule

// ===== hdl/pss_checker.sv =====
// pss_checker: port-level assertions for playlist_shuffle_sequencer_unit.
// Depends on pss_pkg; bound to the top level below.
module pss_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [pss_pkg::SONG_W-1:0] current_song,
    input logic [pss_pkg::SONG_W-1:0] current_position,
    input logic                       list_empty
);
    import pss_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside busy window");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("busy or done held past result");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && list_empty) |-> (current_song == '0 && current_position == '0))
        else $error("empty list reports nonzero song or position");

endmodule

bind playlist_shuffle_sequencer_unit pss_checker u_pss_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .current_song     (current_song),
    .current_position (current_position),
    .list_empty       (list_empty)
);

// ===== dv/tb_playlist_shuffle_sequencer_unit.sv =====
// Self-checking testbench for playlist_shuffle_sequencer_unit.
// Holds its own play-order model in a small scoreboard class; depends on pss_pkg.
module tb_playlist_shuffle_sequencer_unit;
    import pss_pkg::*;

    localparam int N_SONGS = 1024;
    localparam int WATCHDOG = 400000;

    typedef struct packed {
        logic [SONG_W-1:0] song;
        logic [SONG_W-1:0] pos;
        logic              empty;
        logic              shuf;
    } now_playing_t;

    // Tracks the play order and queues what the block must report per word.
    class play_order_board;
        logic [SONG_W-1:0] order_tbl [N_SONGS];
        int unsigned       pos;
        bit                loaded;
        bit                shuf_on;
        int unsigned       len_reg;
        int unsigned       len_held;
        now_playing_t      pending [$];
        int                n_errors;

        function new();
            pos = 0;
            loaded = 0;
            shuf_on = 1;
            len_reg = 0;
            len_held = 0;
            n_errors = 0;
        endfunction

        function bit is_empty();
            return !loaded || len_held == 0;
        endfunction

        // identity order, then Fisher-Yates from the top when shuffle is on
        function void rebuild(logic [31:0] ent);
            logic [30:0] s;
            int unsigned j;
            logic [SONG_W-1:0] t;
            for (int i = 0; i < len_held; i++)
                order_tbl[i] = i[SONG_W-1:0];
            if (shuf_on && len_held > 1)
            begin
                s = ent[30:0];
                for (int i = len_held - 1; i > 0; i--)
                begin
                    s = 31'(LCG_MUL * s + LCG_INC);
                    j = s % (i + 1);
                    t = order_tbl[i];
                    order_tbl[i] = order_tbl[j];
                    order_tbl[j] = t;
                end
            end
            pos = 0;
        endfunction

        function int unsigned locate(int unsigned song);
            for (int p = 0; p < len_held; p++)
                if (order_tbl[p] == song)
                    return p;
            return 0;
        endfunction

        function void note_command(logic [2:0] md, logic [SONG_W-1:0] idx, logic req,
                                   logic [31:0] ent);
            now_playing_t r;
            int unsigned cur, p;
            logic [SONG_W-1:0] t;
            case (md)
                MODE_LOAD:
                begin
                    len_held = len_reg > N_SONGS ? N_SONGS : len_reg;
                    loaded = 1;
                    rebuild(ent);
                end
                MODE_NEXT:
                    if (!is_empty())
                    begin
                        if (pos >= len_held - 1)
                            rebuild(ent);
                        else
                            pos++;
                    end
                MODE_PREV:
                    if (!is_empty() && pos > 0)
                        pos--;
                MODE_SELECT:
                    if (!is_empty() && idx < len_held)
                        pos = locate(idx);
                MODE_SHUFFLE:
                    if (req != shuf_on)
                    begin
                        shuf_on = req;
                        if (!is_empty())
                        begin
                            cur = order_tbl[pos < len_held ? pos : 0];
                            if (shuf_on)
                            begin
                                rebuild(ent);
                                p = locate(cur);
                                t = order_tbl[0];
                                order_tbl[0] = order_tbl[p];
                                order_tbl[p] = t;
                                pos = 0;
                            end
                            else
                            begin
                                for (int i = 0; i < len_held; i++)
                                    order_tbl[i] = i[SONG_W-1:0];
                                pos = cur;
                            end
                        end
                    end
                default: ;
            endcase
            if (is_empty())
                r = '{song: '0, pos: '0, empty: 1'b1, shuf: shuf_on};
            else
            begin
                p = pos < len_held ? pos : 0;
                r = '{song: order_tbl[p], pos: p[SONG_W-1:0], empty: 1'b0, shuf: shuf_on};
            end
            pending = {pending, r};
        endfunction

        function void check_word(now_playing_t got);
            now_playing_t want;
            if (pending.size() == 0)
            begin
                $error("result word with nothing expected");
                n_errors++;
                return;
            end
            want = pending.pop_front();
            if (got.song !== want.song)
            begin
                $error("current_song: expected %0d, got %0d", want.song, got.song);
                n_errors++;
            end
            if (got.pos !== want.pos)
            begin
                $error("current_position: expected %0d, got %0d", want.pos, got.pos);
                n_errors++;
            end
            if (got.empty !== want.empty)
            begin
                $error("list_empty: expected %0d, got %0d", want.empty, got.empty);
                n_errors++;
            end
            if (got.shuf !== want.shuf)
            begin
                $error("shuffle_active: expected %0d, got %0d", want.shuf, got.shuf);
                n_errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [2:0]        mode;
    logic [SONG_W-1:0] song_index;
    logic              shuffle_request;
    logic [31:0]       entropy;
    logic              done;
    logic [SONG_W-1:0] current_song;
    logic [SONG_W-1:0] current_position;
    logic              list_empty;
    logic              shuffle_active;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    play_order_board board;
    int              idle_cycles;
    int              cur_len;

    playlist_shuffle_sequencer_unit #(.MAX_SONGS(N_SONGS)) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .song_index       (song_index),
        .shuffle_request  (shuffle_request),
        .entropy          (entropy),
        .done             (done),
        .current_song     (current_song),
        .current_position (current_position),
        .list_empty       (list_empty),
        .shuffle_active   (shuffle_active),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial
    begin
        clk = 1'b0;
        board = new();
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result side: done is a single-cycle strobe, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_word('{song: current_song, pos: current_position,
                               empty: list_empty, shuf: shuffle_active});
    end

    // watchdog: cycles with neither a command nor a result word accepted
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one, sometimes none at all
    task automatic idle_gap();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2: n = 0;
            9:       n = $urandom_range(10, 40);
            default: n = $urandom_range(1, 4);
        endcase
        repeat (n) @(negedge clk);
    endtask

    // APB write: setup then access; pready is tied high
    task automatic write_length(int unsigned len);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = REG_LIST_LENGTH;
        pwdata = len;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.len_reg = len & 32'h7ff;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // one command word; called at a falling edge, returns at a falling edge
    task automatic send_command(logic [2:0] md, logic [SONG_W-1:0] idx, logic req,
                                logic [31:0] ent);
        mode = md;
        song_index = idx;
        shuffle_request = req;
        entropy = ent;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_command(md, idx, req, ent);
        @(negedge clk);
        start = 1'b0;
    endtask

    // block is idle once the last expected word is in; every command gives one
    task automatic wait_drained();
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // random command, weighted toward navigation over a loaded list
    task automatic random_command();
        logic [2:0]        md;
        logic [SONG_W-1:0] idx;
        int unsigned       k;
        k = $urandom_range(0, 99);
        if (k < 6)
            md = MODE_LOAD;
        else if (k < 40)
            md = MODE_NEXT;
        else if (k < 55)
            md = MODE_PREV;
        else if (k < 80)
            md = MODE_SELECT;
        else if (k < 95)
            md = MODE_SHUFFLE;
        else
            md = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 4) == 0 || cur_len == 0)
            idx = SONG_W'($urandom());
        else
            idx = SONG_W'($urandom_range(0, cur_len - 1));
        send_command(md, idx, 1'($urandom_range(0, 1)), $urandom());
    endtask

    initial
    begin
        int lens [5];
        lens = '{12, 1, 37, 2, 5};
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_LOAD;
        song_index = '0;
        shuffle_request = 1'b0;
        entropy = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_len = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // navigation, shuffle toggles and an undefined mode before any load
        send_command(MODE_NEXT, '0, 1'b0, '0);
        send_command(MODE_PREV, '0, 1'b0, '0);
        send_command(MODE_SELECT, 10'd0, 1'b0, '0);
        send_command(MODE_SHUFFLE, '0, 1'b1, '0);
        send_command(MODE_SHUFFLE, '0, 1'b0, 32'hffff_ffff);
        send_command(MODE_SHUFFLE, '0, 1'b1, '0);
        send_command(3'd7, 10'h3ff, 1'b1, 32'hffff_ffff);

        // zero-length load leaves the list empty
        send_command(MODE_LOAD, '0, 1'b0, 32'h1234_5678);
        send_command(MODE_NEXT, '0, 1'b0, '0);
        wait_drained();

        // largest list, saturating length value, both seed extremes
        write_length(2047);
        send_command(MODE_LOAD, '0, 1'b0, 32'hffff_ffff);
        send_command(MODE_SELECT, 10'h3ff, 1'b0, '0);
        send_command(MODE_NEXT, '0, 1'b0, '0);
        send_command(MODE_PREV, '0, 1'b0, '0);
        send_command(MODE_SHUFFLE, '0, 1'b0, '0);
        send_command(MODE_SHUFFLE, '0, 1'b1, 32'h8000_0000);
        wait_drained();

        write_length(3);
        cur_len = 3;
        send_command(MODE_LOAD, '0, 1'b0, 32'h0);
        send_command(MODE_PREV, '0, 1'b0, '0);
        send_command(MODE_NEXT, '0, 1'b0, '0);
        send_command(MODE_NEXT, '0, 1'b0, '0);
        send_command(MODE_NEXT, '0, 1'b0, 32'h5a5a_a5a5);
        send_command(MODE_SELECT, 10'd3, 1'b0, '0);
        send_command(MODE_SELECT, 10'd2, 1'b0, '0);
        send_command(3'd5, 10'd1, 1'b0, '0);
        send_command(3'd6, 10'd1, 1'b0, '0);
        wait_drained();

        // random phases over small lists; a load picks up each new length
        foreach (lens[ph])
        begin
            write_length(lens[ph]);
            cur_len = lens[ph];
            idle_gap();
            send_command(MODE_LOAD, '0, 1'b0, $urandom());
            for (int n = 0; n < 15; n++)
            begin
                if ($urandom_range(0, 2) != 0)
                    idle_gap();
                random_command();
            end
            // sender holds off until every expected word is back
            wait_drained();
        end

        write_length(0);
        cur_len = 0;
        send_command(MODE_LOAD, '0, 1'b0, '0);
        send_command(MODE_SELECT, 10'd0, 1'b0, '0);

        wait_drained();
        repeat (50) @(negedge clk);
        if (board.n_errors == 0 && board.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pss_pkg.sv
hdl/pss_divmod.sv
hdl/pss_order_ram.sv
hdl/playlist_shuffle_sequencer_unit.sv
hdl/pss_checker.sv
dv/tb_playlist_shuffle_sequencer_unit.sv
